// ===== rtl/core/fsnf_pkg.sv =====
// Shared types, character codes and helpers for the format string number formatter.
// Used by fsnf_div10 and format_string_number_formatter_top; depends on nothing.
package fsnf_pkg;

  localparam int ARG_W       = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int NIB_N       = (ARG_W + 3) / 4;
  localparam int NIB_IDX_W   = $clog2(NIB_N);
  localparam int DEC_N       = 10;
  localparam int DEC_IDX_W   = $clog2(DEC_N + 1);
  localparam int RECIP_SHIFT = 35;

  typedef logic [ARG_W-1:0]   arg_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    arg_t   quot;
    digit_t rem;
  } div10_t;

  localparam arg_t RECIP_10 = 32'hCCCC_CCCD;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_PCT   = 8'h25;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_A_UP  = 8'h41;
  localparam char_t CH_A_LO  = 8'h61;
  localparam char_t CH_C     = 8'h63;
  localparam char_t CH_D     = 8'h64;
  localparam char_t CH_X_LO  = 8'h78;
  localparam char_t CH_X_UP  = 8'h58;

  function automatic char_t hex_char(input digit_t nib, input logic upper);
    char_t base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (nib < digit_t'(10)) begin
      return CH_ZERO + char_t'(nib);
    end
    return base + char_t'(nib) - char_t'(10);
  endfunction

  function automatic char_t dec_char(input digit_t dig);
    return CH_ZERO + char_t'(dig);
  endfunction

endpackage

// ===== rtl/core/fsnf_div10.sv =====
// Divide-by-ten unit: quotient by reciprocal multiply, remainder by shift-add and subtract.
// Depends on fsnf_pkg.
module fsnf_div10 (
  input  fsnf_pkg::arg_t   dividend,
  output fsnf_pkg::div10_t result
);
  import fsnf_pkg::*;

  logic [2*ARG_W-1:0] prod;
  arg_t               quot;
  arg_t               times10;
  arg_t               diff;

  assign prod    = {{ARG_W{1'b0}}, dividend} * {{ARG_W{1'b0}}, RECIP_10};
  assign quot    = ARG_W'(prod >> RECIP_SHIFT);
  assign times10 = (quot << 3) + (quot << 1);
  assign diff    = dividend - times10;

  assign result.quot = quot;
  assign result.rem  = diff[DIGIT_W-1:0];

endmodule

// ===== rtl/core/format_string_number_formatter_top.sv =====
// Top level of the format string number formatter: escape tracking, sequencer and output beat.
// Depends on fsnf_pkg and fsnf_div10.
//
// Usage: the input channel (in_valid / in_stall) carries one format character and a
// 32-bit argument per beat. The output channel (out_valid / out_stall) carries one
// character per beat; out_last_char marks the final character of an input beat.
// An escape-opening '%' beat or a zero character produces no output beat at all.
// The block takes one input beat at a time: in_stall is high until the sequencer
// has handed the last character of the current beat to the output register.
// Steps per input beat: a '%', a zero character or an unknown specifier is taken in S_IDLE
// alone; an echoed character, %c or %% passes through S_ONE; hex first skips leading zero
// nibbles, one per cycle, then emits one character per nibble in S_HEX; decimal first
// fills the digit store in S_DIV, the single divide-by-ten unit producing one digit per
// cycle, then emits an optional '-' in S_SIGN and the digits in S_DEC. Each emitted
// character goes from the sequencer into the output register, which drives out_valid.
// A stalled output beat holds; the sequencer waits until the register frees up,
// and a new input beat may be taken while the last character still waits.
// Reset (rst_n low, synchronous) clears the escape flag, the sequencer and out_valid.
module format_string_number_formatter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  fsnf_pkg::char_t                      in_fmt_char,
  input  logic signed [fsnf_pkg::ARG_W-1:0]    in_arg_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output fsnf_pkg::char_t                      out_char,
  output logic                                 out_last_char
);
  import fsnf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ONE  = 3'd1;
  localparam logic [2:0] S_HEX  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SIGN = 3'd4;
  localparam logic [2:0] S_DEC  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic                 esc_r, esc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  char_t                out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  char_t                char_r, char_nxt;
  logic                 upper_r, upper_nxt;
  logic                 neg_r, neg_nxt;
  logic                 seen_r, seen_nxt;
  arg_t                 work_r, work_nxt;
  logic [NIB_IDX_W-1:0] nib_r, nib_nxt;
  logic [DEC_IDX_W-1:0] cnt_r, cnt_nxt;
  digit_t               dig_r [DEC_N];
  digit_t               dig_nxt [DEC_N];

  arg_t                 arg_u;
  digit_t               top_nib;
  digit_t               dec_dig;
  logic                 slot_free;
  logic                 load;
  char_t                ld_char;
  logic                 ld_last;
  div10_t               div_res;

  fsnf_div10 u_div10 (
    .dividend (work_r),
    .result   (div_res)
  );

  assign arg_u     = arg_t'(in_arg_value);
  assign top_nib   = work_r[ARG_W-1 -: DIGIT_W];
  assign dec_dig   = dig_r[cnt_r - 1'b1];
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    esc_nxt   = esc_r;
    char_nxt  = char_r;
    upper_nxt = upper_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    work_nxt  = work_r;
    nib_nxt   = nib_r;
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    load      = 1'b0;
    ld_char   = CH_NUL;
    ld_last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          esc_nxt = 1'b0;
          if (in_fmt_char == CH_NUL) begin
            esc_nxt = 1'b0;
          end else if (!esc_r) begin
            if (in_fmt_char == CH_PCT) begin
              esc_nxt = 1'b1;
            end else begin
              char_nxt  = in_fmt_char;
              state_nxt = S_ONE;
            end
          end else begin
            case (in_fmt_char)
              CH_C: begin
                char_nxt  = arg_u[CHAR_W-1:0];
                state_nxt = S_ONE;
              end
              CH_X_LO, CH_X_UP: begin
                work_nxt  = arg_u;
                upper_nxt = (in_fmt_char == CH_X_UP);
                seen_nxt  = 1'b0;
                nib_nxt   = NIB_IDX_W'(NIB_N - 1);
                state_nxt = S_HEX;
              end
              CH_D: begin
                neg_nxt   = arg_u[ARG_W-1];
                work_nxt  = arg_u[ARG_W-1] ? (~arg_u + 1'b1) : arg_u;
                cnt_nxt   = '0;
                state_nxt = S_DIV;
              end
              CH_PCT: begin
                char_nxt  = CH_PCT;
                state_nxt = S_ONE;
              end
              default: begin
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end
      S_ONE: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_char   = char_r;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_HEX: begin
        if (top_nib == '0 && !seen_r && nib_r != '0) begin
          work_nxt = work_r << DIGIT_W;
          nib_nxt  = nib_r - 1'b1;
        end else if (slot_free) begin
          load     = 1'b1;
          ld_char  = hex_char(top_nib, upper_r);
          ld_last  = (nib_r == '0);
          seen_nxt = 1'b1;
          work_nxt = work_r << DIGIT_W;
          nib_nxt  = nib_r - 1'b1;
          if (nib_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        dig_nxt[cnt_r] = div_res.rem;
        work_nxt       = div_res.quot;
        cnt_nxt        = cnt_r + 1'b1;
        if (div_res.quot == '0) begin
          state_nxt = neg_r ? S_SIGN : S_DEC;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_char   = CH_MINUS;
          ld_last   = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_char = dec_char(dec_dig);
          ld_last = (cnt_r == DEC_IDX_W'(1));
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == DEC_IDX_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = load | (out_valid_r & out_stall);
    out_char_nxt  = load ? ld_char : out_char_r;
    out_last_nxt  = load ? ld_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    char_r     <= char_nxt;
    upper_r    <= upper_nxt;
    neg_r      <= neg_nxt;
    seen_r     <= seen_nxt;
    work_r     <= work_nxt;
    nib_r      <= nib_nxt;
    cnt_r      <= cnt_nxt;
    dig_r      <= dig_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

endmodule
